### hdl/bptc_pkg.sv
// Package: shared types and constants for the button press timer.
`timescale 1ns / 1ps

package bptc_pkg;

  localparam logic [15:0] HOLD_STEP = 16'd10;
  localparam logic [15:0] HOLD_MAX  = 16'd50000;

  localparam int CHORD_A = 2;
  localparam int CHORD_B = 3;

  localparam logic [15:0] PRESS_THRESHOLD_RESET = 16'd50;
  localparam logic [15:0] MODE_DELAY_RESET      = 16'd2000;

  localparam logic REG_PRESS_THRESHOLD = 1'b0;
  localparam logic REG_MODE_DELAY      = 1'b1;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic [15:0] cnt;
    logic        down;
    logic        hit;
  } lane_t;

  typedef struct packed {
    logic [2:0]  button;
    logic [15:0] hold_time;
    logic        press_event;
    logic        uart_mode;
    logic        mode_enter;
    logic        mode_exit;
  } res_t;

endpackage

### hdl/bptc_lane.sv
// One button lane: hold counter with saturation and threshold match.
`timescale 1ns / 1ps

module bptc_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                level,
  input  logic [15:0]         press_threshold,
  output bptc_pkg::lane_t     lane
);

  logic [15:0] cnt;
  logic [15:0] cnt_next;
  logic        pressed;

  assign pressed = ~level;

  always_comb begin
    cnt_next = cnt;
    if (tick) begin
      if (!pressed) begin
        cnt_next = '0;
      end else if (cnt < bptc_pkg::HOLD_MAX) begin
        cnt_next = cnt + bptc_pkg::HOLD_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  assign lane.cnt  = cnt_next;
  assign lane.down = tick & pressed;
  assign lane.hit  = (cnt_next == press_threshold);

endmodule

### hdl/bptc_merge.sv
// Merge stage: single-press detect, chord mode tracking and result assembly.
`timescale 1ns / 1ps

module bptc_merge #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick,
  input  logic                                clear,
  input  bptc_pkg::lane_t [NUM_BUTTONS-1:0]   lanes,
  input  logic [15:0]                         mode_hold_delay,
  output bptc_pkg::res_t                      res
);

  localparam int CW = $clog2(NUM_BUTTONS + 1);

  logic [CW-1:0]          cur;
  logic [CW-1:0]          cur_next;
  logic                   mode;
  logic                   mode_next;
  logic [NUM_BUTTONS-1:0] down;
  logic [NUM_BUTTONS-1:0] hit;
  logic                   single;
  logic                   single_hit;
  logic [CW-1:0]          last;
  logic                   chord;
  logic                   ev;
  logic                   ent;
  logic                   ext;
  logic [15:0]            sel_time;

  always_comb begin
    last = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      down[i] = lanes[i].down;
      hit[i]  = lanes[i].hit;
      if (lanes[i].down) begin
        last = CW'(i + 1);
      end
    end
  end

  // exactly one button down
  assign single     = (down != '0) && ((down & (down - NUM_BUTTONS'(1))) == '0);
  assign single_hit = single && ((down & hit) != '0);
  assign chord      = (lanes[bptc_pkg::CHORD_A].cnt > mode_hold_delay) &&
                      (lanes[bptc_pkg::CHORD_B].cnt > mode_hold_delay);

  always_comb begin
    cur_next  = cur;
    mode_next = mode;
    ev        = 1'b0;
    ent       = 1'b0;
    ext       = 1'b0;
    if (clear) begin
      cur_next = '0;
    end else if (tick) begin
      if (chord) begin
        if (!mode) begin
          mode_next = 1'b1;
          ent       = 1'b1;
          cur_next  = '0;
        end
      end else begin
        mode_next = 1'b0;
        ext       = mode;
        if (single_hit) begin
          cur_next = last;
          ev       = 1'b1;
        end else begin
          cur_next = '0;
        end
      end
    end
  end

  always_comb begin
    sel_time = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (cur_next == CW'(i + 1)) begin
        sel_time = lanes[i].cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      mode <= 1'b0;
    end else begin
      cur  <= cur_next;
      mode <= mode_next;
    end
  end

  assign res.button      = cur_next[2:0];
  assign res.hold_time   = sel_time;
  assign res.press_event = ev;
  assign res.uart_mode   = mode_next;
  assign res.mode_enter  = ent;
  assign res.mode_exit   = ext;

endmodule

### hdl/button_press_timer_chord_mode.sv
// A result word is computed from its input word and registered into the output buffer when that word is accepted.
// Throughput: one word per cycle while the output buffer is not full; all button lanes update in parallel.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (synchronous, active high): lane counters and the merge stage's button and mode clear,
// registers return to threshold 50 and mode delay 2000, output buffer empties.
`timescale 1ns / 1ps

module button_press_timer_chord_mode #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [15:0]            wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [NUM_BUTTONS-1:0] button_levels,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             reported_button,
  output logic [15:0]            reported_time,
  output logic                   press_event,
  output logic                   uart_mode,
  output logic                   mode_enter,
  output logic                   mode_exit
);

  logic [15:0] press_threshold;
  logic [15:0] mode_hold_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= bptc_pkg::PRESS_THRESHOLD_RESET;
      mode_hold_delay <= bptc_pkg::MODE_DELAY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bptc_pkg::REG_PRESS_THRESHOLD: press_threshold <= wr_data;
        bptc_pkg::REG_MODE_DELAY:      mode_hold_delay <= wr_data;
        default: ;
      endcase
    end
  end

  logic accept;
  logic tick;
  logic clear;

  assign accept = in_valid && !in_stall;
  assign tick   = accept && (command == bptc_pkg::CMD_TICK);
  assign clear  = accept && (command == bptc_pkg::CMD_CLEAR);

  bptc_pkg::lane_t [NUM_BUTTONS-1:0] lanes;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bptc_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .tick            (tick),
      .level           (button_levels[g]),
      .press_threshold (press_threshold),
      .lane            (lanes[g])
    );
  end

  bptc_pkg::res_t res;

  bptc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .clear           (clear),
    .lanes           (lanes),
    .mode_hold_delay (mode_hold_delay),
    .res             (res)
  );

  // two-entry output buffer, head in buf0
  bptc_pkg::res_t buf0;
  bptc_pkg::res_t buf1;
  logic [1:0]     count;
  logic           pop;

  assign pop      = out_valid && !out_stall;
  assign in_stall = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({accept, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (count == 2'd2) ? buf1 : res;
    end else if (accept && count == 2'd0) begin
      buf0 <= res;
    end
    if (accept && !pop && count == 2'd1) begin
      buf1 <= res;
    end
  end

  assign out_valid       = (count != 2'd0);
  assign reported_button = buf0.button;
  assign reported_time   = buf0.hold_time;
  assign press_event     = buf0.press_event;
  assign uart_mode       = buf0.uart_mode;
  assign mode_enter      = buf0.mode_enter;
  assign mode_exit       = buf0.mode_exit;

`ifndef SYNTHESIS
  a_enter_exit_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mode_enter && mode_exit))
    else $error("mode enter and exit in one word");

  a_enter_clears : assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_enter) |-> (reported_button == 3'd0 && uart_mode && !press_event))
    else $error("mode enter word reports a button");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output buffer");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
